@@ sv/sli_pkg.sv @@
`timescale 1ns / 1ps
package sli_pkg;

  localparam int OP_BITS = 2;

  typedef enum logic [OP_BITS-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LIST   = 2'd2
  } sli_op_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_LISTED    = 3'd4,
    ST_EMPTY     = 3'd5
  } sli_status_e;

  // What every cell of the chain does in the current cycle.
  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_ROTATE = 2'd3
  } sli_cmd_e;

  typedef struct packed {
    sli_cmd_e cmd;
    logic     flag_en;
  } sli_ctrl_t;

endpackage

@@ sv/sli_in_if.sv @@
`timescale 1ns / 1ps
interface sli_in_if #(
  parameter int KEY_BITS     = 8,
  parameter int PAYLOAD_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic [sli_pkg::OP_BITS-1:0] operation;
  logic [KEY_BITS-1:0]         key;
  logic [PAYLOAD_BITS-1:0]     payload;

  modport source (output valid, operation, key, payload, input ready);
  modport sink   (input valid, operation, key, payload, output ready);
endinterface

@@ sv/sli_out_if.sv @@
`timescale 1ns / 1ps
interface sli_out_if #(
  parameter int KEY_BITS     = 8,
  parameter int PAYLOAD_BITS = 16,
  parameter int POS_BITS     = 5
);
  logic                    valid;
  logic                    ready;
  sli_pkg::sli_status_e    status;
  logic [KEY_BITS-1:0]     out_key;
  logic [PAYLOAD_BITS-1:0] out_payload;
  logic [POS_BITS-1:0]     position;
  logic                    last;

  modport source (output valid, status, out_key, out_payload, position, last, input ready);
  modport sink   (input valid, status, out_key, out_payload, position, last, output ready);
endinterface

@@ sv/sli_cell.sv @@
`timescale 1ns / 1ps
module sli_cell #(
  parameter int IDX          = 0,
  parameter int KEY_BITS     = 8,
  parameter int PAYLOAD_BITS = 16,
  parameter int POS_BITS     = 5
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sli_pkg::sli_ctrl_t      ctrl_i,
  input  logic [POS_BITS-1:0]     count_i,
  input  logic [KEY_BITS-1:0]     cmp_key_i,
  input  logic [KEY_BITS-1:0]     new_key_i,
  input  logic [PAYLOAD_BITS-1:0] new_pay_i,
  input  logic                    left_gt_i,
  input  logic [KEY_BITS-1:0]     left_key_i,
  input  logic [PAYLOAD_BITS-1:0] left_pay_i,
  input  logic [KEY_BITS-1:0]     right_key_i,
  input  logic [PAYLOAD_BITS-1:0] right_pay_i,
  input  logic [KEY_BITS-1:0]     head_key_i,
  input  logic [PAYLOAD_BITS-1:0] head_pay_i,
  output logic [KEY_BITS-1:0]     key_o,
  output logic [PAYLOAD_BITS-1:0] pay_o,
  output logic                    gt_o,
  output logic                    ge_o,
  output logic                    eq_o
);

  logic [KEY_BITS-1:0]     key_q, key_d;
  logic [PAYLOAD_BITS-1:0] pay_q, pay_d;
  logic                    gt_q, ge_q, eq_q;
  logic                    occ, at_end, has_next, is_tail;

  assign occ      = POS_BITS'(IDX) < count_i;
  assign at_end   = POS_BITS'(IDX) == count_i;
  assign has_next = POS_BITS'(IDX + 1) < count_i;
  assign is_tail  = POS_BITS'(IDX + 1) == count_i;

  // Compare flags are registered when an item is accepted and held until the chain applies that item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gt_q <= 1'b0;
      ge_q <= 1'b0;
      eq_q <= 1'b0;
    end else if (ctrl_i.flag_en) begin
      gt_q <= occ && (key_q > cmp_key_i);
      ge_q <= occ && (key_q >= cmp_key_i);
      eq_q <= occ && (key_q == cmp_key_i);
    end
  end

  always_comb begin
    key_d = key_q;
    pay_d = pay_q;
    unique case (ctrl_i.cmd)
      sli_pkg::CMD_HOLD: begin
      end
      sli_pkg::CMD_INSERT: begin
        // Cells holding larger keys move up by one; the first of them takes the new item.
        if (gt_q || at_end) begin
          if (left_gt_i) begin
            key_d = left_key_i;
            pay_d = left_pay_i;
          end else begin
            key_d = new_key_i;
            pay_d = new_pay_i;
          end
        end
      end
      sli_pkg::CMD_DELETE: begin
        if (ge_q && has_next) begin
          key_d = right_key_i;
          pay_d = right_pay_i;
        end
      end
      sli_pkg::CMD_ROTATE: begin
        if (has_next) begin
          key_d = right_key_i;
          pay_d = right_pay_i;
        end else if (is_tail) begin
          key_d = head_key_i;
          pay_d = head_pay_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pay_q <= pay_d;
  end

  assign key_o = key_q;
  assign pay_o = pay_q;
  assign gt_o  = gt_q;
  assign ge_o  = ge_q;
  assign eq_o  = eq_q;

endmodule

@@ sv/sorted_list_insert_delete.sv @@
`timescale 1ns / 1ps
// Sorted table of up to DEPTH key/payload entries held in a chain of cells, one entry per
// cell in ascending key order. On insert and delete every cell compares its key with the
// item key in the cycle the item is accepted; once the output register is free, the chain
// shifts by one place (unless the table is full or no entry matches) and the result is
// written to the output register. A list operation rotates the chain once per cycle while
// the output register is free, emitting the head cell: one result per entry, one if empty.
// The input is ready only while no item is in work; the output register lets a finished
// result wait while the next item is accepted; that item holds until the result is taken.
module sorted_list_insert_delete #(
  parameter int DEPTH        = 16,
  parameter int KEY_BITS     = 8,
  parameter int PAYLOAD_BITS = 16
) (
  input logic     clk_i,
  input logic     rst_ni,
  sli_in_if.sink  in_i,
  sli_out_if.source out_o
);

  localparam int POS_BITS = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_APPLY = 3'b010,
    S_LIST  = 3'b100
  } sli_state_e;

  sli_state_e               state_q, state_d;
  logic [POS_BITS-1:0]      count_q, count_d;
  logic [POS_BITS-1:0]      list_idx_q, list_idx_d;
  logic [sli_pkg::OP_BITS-1:0] op_q;
  logic [KEY_BITS-1:0]      op_key_q;
  logic [PAYLOAD_BITS-1:0]  op_pay_q;

  logic                     out_valid_q;
  sli_pkg::sli_status_e     status_q, res_status;
  logic [KEY_BITS-1:0]      out_key_q, res_key;
  logic [PAYLOAD_BITS-1:0]  out_pay_q, res_pay;
  logic [POS_BITS-1:0]      pos_q, res_pos;
  logic                     last_q, res_last, res_valid;

  logic                     in_acc, out_free;
  sli_pkg::sli_ctrl_t       ctrl;

  logic [KEY_BITS-1:0]      key_w [DEPTH];
  logic [PAYLOAD_BITS-1:0]  pay_w [DEPTH];
  logic [DEPTH-1:0]         gt_w, ge_w, eq_w;
  logic [DEPTH-1:0]         first_gt, first_eq;
  logic [POS_BITS-1:0]      ins_pos, del_pos;
  logic [PAYLOAD_BITS-1:0]  del_pay;
  logic                     found;

  assign in_acc   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign out_free = !out_valid_q || out_o.ready;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                    left_gt;
    logic [KEY_BITS-1:0]     left_key, right_key;
    logic [PAYLOAD_BITS-1:0] left_pay, right_pay;

    if (i == 0) begin : g_first
      assign left_gt  = 1'b0;
      assign left_key = op_key_q;
      assign left_pay = op_pay_q;
    end else begin : g_mid
      assign left_gt  = gt_w[i-1];
      assign left_key = key_w[i-1];
      assign left_pay = pay_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_key = key_w[i];
      assign right_pay = pay_w[i];
    end else begin : g_inner
      assign right_key = key_w[i+1];
      assign right_pay = pay_w[i+1];
    end

    sli_cell #(
      .IDX         (i),
      .KEY_BITS    (KEY_BITS),
      .PAYLOAD_BITS(PAYLOAD_BITS),
      .POS_BITS    (POS_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .count_i    (count_q),
      .cmp_key_i  (in_i.key),
      .new_key_i  (op_key_q),
      .new_pay_i  (op_pay_q),
      .left_gt_i  (left_gt),
      .left_key_i (left_key),
      .left_pay_i (left_pay),
      .right_key_i(right_key),
      .right_pay_i(right_pay),
      .head_key_i (key_w[0]),
      .head_pay_i (pay_w[0]),
      .key_o      (key_w[i]),
      .pay_o      (pay_w[i]),
      .gt_o       (gt_w[i]),
      .ge_o       (ge_w[i]),
      .eq_o       (eq_w[i])
    );
  end

  // The flags are thermometer codes over the sorted chain, so their rising edge marks the
  // insert position and the first matching entry.
  assign first_gt = gt_w & ~{gt_w[DEPTH-2:0], 1'b0};
  assign first_eq = eq_w & ~{ge_w[DEPTH-2:0], 1'b0};
  assign found    = |first_eq;

  always_comb begin
    ins_pos = '0;
    del_pos = '0;
    del_pay = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_gt[i]) ins_pos = ins_pos | POS_BITS'(i);
      if (first_eq[i]) begin
        del_pos = del_pos | POS_BITS'(i);
        del_pay = del_pay | pay_w[i];
      end
    end
    if (!(|gt_w)) ins_pos = count_q;
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    list_idx_d = list_idx_q;
    ctrl.cmd   = sli_pkg::CMD_HOLD;
    ctrl.flag_en = in_acc;
    res_valid  = 1'b0;
    res_status = sli_pkg::ST_INSERTED;
    res_key    = '0;
    res_pay    = '0;
    res_pos    = '0;
    res_last   = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_i.operation)
            sli_pkg::OP_INSERT, sli_pkg::OP_DELETE: state_d = S_APPLY;
            sli_pkg::OP_LIST: begin
              state_d    = S_LIST;
              list_idx_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_APPLY: begin
        if (out_free) begin
          res_valid = 1'b1;
          res_key   = op_key_q;
          state_d   = S_IDLE;
          if (op_q == sli_pkg::OP_INSERT) begin
            if (count_q == POS_BITS'(DEPTH)) begin
              res_status = sli_pkg::ST_FULL;
              res_pos    = count_q;
            end else begin
              res_status = sli_pkg::ST_INSERTED;
              res_pay    = op_pay_q;
              res_pos    = ins_pos;
              ctrl.cmd   = sli_pkg::CMD_INSERT;
              count_d    = count_q + POS_BITS'(1);
            end
          end else if (found) begin
            res_status = sli_pkg::ST_DELETED;
            res_pay    = del_pay;
            res_pos    = del_pos;
            ctrl.cmd   = sli_pkg::CMD_DELETE;
            count_d    = count_q - POS_BITS'(1);
          end else begin
            res_status = sli_pkg::ST_NOT_FOUND;
            res_pos    = count_q;
          end
        end
      end
      S_LIST: begin
        if (out_free) begin
          res_valid = 1'b1;
          if (count_q == '0) begin
            res_status = sli_pkg::ST_EMPTY;
            state_d    = S_IDLE;
          end else begin
            // After count_q rotations the chain is back in its original order.
            res_status = sli_pkg::ST_LISTED;
            res_key    = key_w[0];
            res_pay    = pay_w[0];
            res_pos    = list_idx_q;
            res_last   = (list_idx_q + POS_BITS'(1)) == count_q;
            ctrl.cmd   = sli_pkg::CMD_ROTATE;
            list_idx_d = list_idx_q + POS_BITS'(1);
            if (res_last) state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      list_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      list_idx_q <= list_idx_d;
      if (res_valid) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q     <= in_i.operation;
      op_key_q <= in_i.key;
      op_pay_q <= in_i.payload;
    end
    if (res_valid) begin
      status_q  <= res_status;
      out_key_q <= res_key;
      out_pay_q <= res_pay;
      pos_q     <= res_pos;
      last_q    <= res_last;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = status_q;
  assign out_o.out_key     = out_key_q;
  assign out_o.out_payload = out_pay_q;
  assign out_o.position    = pos_q;
  assign out_o.last        = last_q;

endmodule

@@ sv/sli_checker.sv @@
`timescale 1ns / 1ps
module sli_checker #(
  parameter int DEPTH        = 16,
  parameter int KEY_BITS     = 8,
  parameter int PAYLOAD_BITS = 16,
  parameter int POS_BITS     = 5
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic [sli_pkg::OP_BITS-1:0] in_operation_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input sli_pkg::sli_status_e        out_status_i,
  input logic [KEY_BITS-1:0]         out_key_i,
  input logic [PAYLOAD_BITS-1:0]     out_payload_i,
  input logic [POS_BITS-1:0]         out_position_i,
  input logic                        out_last_i
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i) &&
      $stable(out_key_i) && $stable(out_payload_i) && $stable(out_position_i) &&
      $stable(out_last_i))
    else $error("stalled result changed");

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_operation_i == sli_pkg::OP_INSERT ||
      in_operation_i == sli_pkg::OP_DELETE || in_operation_i == sli_pkg::OP_LIST)
    |=> !in_ready_i)
    else $error("input accepted while an item is in work");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_position_i <= POS_BITS'(DEPTH))
    else $error("position beyond table depth");

  // Every result other than a listed entry is the only result of its item.
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != sli_pkg::ST_LISTED |-> out_last_i)
    else $error("single result without last mark");

endmodule

bind sorted_list_insert_delete sli_checker #(
  .DEPTH       (DEPTH),
  .KEY_BITS    (KEY_BITS),
  .PAYLOAD_BITS(PAYLOAD_BITS),
  .POS_BITS    (POS_BITS)
) u_sli_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_operation_i(in_i.operation),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_status_i  (out_o.status),
  .out_key_i     (out_o.out_key),
  .out_payload_i (out_o.out_payload),
  .out_position_i(out_o.position),
  .out_last_i    (out_o.last)
);
